/* hw/rtl/dxt_pkg.sv */
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, format codes and fixed-point helpers for the S3TC block
// decoder: 565 expansion and exact constant divides by reciprocal multiply.
// ----------------------------------------------------------------------------
package dxt_pkg;

  typedef logic [1:0] fmt_t;

  localparam fmt_t FMT_ONE_BIT  = 2'd0;
  localparam fmt_t FMT_EXPLICIT = 2'd1;
  localparam fmt_t FMT_INTERP   = 2'd2;

  // channel order inside a colour
  localparam int CH_R = 2;
  localparam int CH_G = 1;
  localparam int CH_B = 0;

  localparam logic [1:0] IDX_BLACK = 2'd3;
  localparam logic [3:0] LAST_POS  = 4'd15;

  localparam logic [9:0]  RECIP3 = 10'd683;   // ceil(2^11 / 3)
  localparam logic [11:0] RECIP7 = 12'd2341;  // ceil(2^14 / 7)
  localparam logic [10:0] RECIP5 = 11'd1639;  // ceil(2^13 / 5)

  typedef logic [2:0][7:0] rgb_t;

  // stage one: endpoints expanded, numerators formed
  typedef struct packed {
    fmt_t             fmt;
    logic             four;
    logic             gt;
    rgb_t             c0;
    rgb_t             c1;
    logic [2:0][9:0]  num2;
    logic [2:0][9:0]  num3;
    logic [5:0][10:0] anum;
    logic [63:0]      aw;
    logic [31:0]      cidx;
  } s1_t;

  // stage two: full palette and alpha levels of one block
  typedef struct packed {
    fmt_t            fmt;
    logic            four;
    logic [3:0][2:0][7:0] col;
    logic [7:0][7:0] alev;
    logic [63:0]     aw;
    logic [31:0]     cidx;
  } blk_pal_t;

  function automatic rgb_t expand565(input logic [15:0] v);
    rgb_t c;
    c[CH_R] = {v[15:11], v[15:13]};
    c[CH_G] = {v[10:5], v[10:9]};
    c[CH_B] = {v[4:0], v[4:2]};
    return c;
  endfunction

  // exact for x < 2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * {10'd0, RECIP3};
    return p[18:11];
  endfunction

  // exact for x < 5461
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * {11'd0, RECIP7};
    return p[21:14];
  endfunction

  // exact for x < 2730
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * {11'd0, RECIP5};
    return p[20:13];
  endfunction

endpackage

/* hw/rtl/dxt_blk_if.sv */
// ----------------------------------------------------------------------------
// dxt_blk_if
// Compressed block channel: alpha half and colour half of one 4x4 block.
// ----------------------------------------------------------------------------
interface dxt_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_word;
  logic [63:0] color_word;

  modport source (output valid, output alpha_word, output color_word, input ready);
  modport sink   (input valid, input alpha_word, input color_word, output ready);
endinterface

/* hw/rtl/dxt_texel_if.sv */
// ----------------------------------------------------------------------------
// dxt_texel_if
// Texel channel: one RGBA texel with its position in the block.
// ----------------------------------------------------------------------------
interface dxt_texel_if;
  logic       valid;
  logic       ready;
  logic [7:0] texel_red;
  logic [7:0] texel_green;
  logic [7:0] texel_blue;
  logic [7:0] texel_alpha;
  logic [3:0] texel_position;
  logic       last_texel;

  modport source (output valid, output texel_red, output texel_green, output texel_blue,
                  output texel_alpha, output texel_position, output last_texel,
                  input ready);
  modport sink   (input valid, input texel_red, input texel_green, input texel_blue,
                  input texel_alpha, input texel_position, input last_texel,
                  output ready);
endinterface

/* hw/rtl/dxt_palette.sv */
// ----------------------------------------------------------------------------
// dxt_palette
// Two pipeline stages that build the block palette: endpoint expansion and
// weighted sums, then constant divides to colour and alpha levels.
// ----------------------------------------------------------------------------
module dxt_palette
  import dxt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  fmt_t      fmt,
  dxt_blk_if.sink   in_blk,
  output logic      pal_valid,
  input  logic      pal_ready,
  output blk_pal_t  pal
);

  logic     s1_v_r;
  s1_t      s1_r;
  s1_t      s1_nxt;
  logic     s1_ready;
  logic     s2_v_r;
  blk_pal_t s2_r;
  blk_pal_t s2_nxt;
  logic     s2_ready;

  assign s2_ready     = !s2_v_r || pal_ready;
  assign s1_ready     = !s1_v_r || s2_ready;
  assign in_blk.ready = s1_ready;

  // stage one
  always_comb begin
    logic [15:0] e0;
    logic [15:0] e1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [9:0]  p0;
    logic [9:0]  p1;
    fmt_t        f;
    e0 = in_blk.color_word[15:0];
    e1 = in_blk.color_word[31:16];
    a0 = in_blk.alpha_word[7:0];
    a1 = in_blk.alpha_word[15:8];
    f  = (fmt == FMT_EXPLICIT || fmt == FMT_INTERP) ? fmt : FMT_ONE_BIT;
    s1_nxt.fmt  = f;
    s1_nxt.four = (f != FMT_ONE_BIT) || (e0 > e1);
    s1_nxt.gt   = a0 > a1;
    s1_nxt.c0   = expand565(e0);
    s1_nxt.c1   = expand565(e1);
    s1_nxt.aw   = in_blk.alpha_word;
    s1_nxt.cidx = in_blk.color_word[63:32];
    for (int c = 0; c < 3; c++) begin
      p0 = {2'b00, s1_nxt.c0[c]};
      p1 = {2'b00, s1_nxt.c1[c]};
      if (s1_nxt.four) begin
        s1_nxt.num2[c] = {p0[8:0], 1'b0} + p1;
        s1_nxt.num3[c] = p0 + {p1[8:0], 1'b0};
      end else begin
        s1_nxt.num2[c] = p0 + p1;
        s1_nxt.num3[c] = '0;
      end
    end
    for (int k = 0; k < 6; k++) begin
      if (s1_nxt.gt) begin
        s1_nxt.anum[k] = 11'(6 - k) * {3'b000, a0} + 11'(1 + k) * {3'b000, a1};
      end else if (k < 4) begin
        s1_nxt.anum[k] = 11'(4 - k) * {3'b000, a0} + 11'(1 + k) * {3'b000, a1};
      end else begin
        s1_nxt.anum[k] = '0;
      end
    end
  end

  // stage two
  always_comb begin
    s2_nxt.fmt    = s1_r.fmt;
    s2_nxt.four   = s1_r.four;
    s2_nxt.aw     = s1_r.aw;
    s2_nxt.cidx   = s1_r.cidx;
    s2_nxt.col[0] = s1_r.c0;
    s2_nxt.col[1] = s1_r.c1;
    for (int c = 0; c < 3; c++) begin
      if (s1_r.four) begin
        s2_nxt.col[2][c] = div3(s1_r.num2[c]);
        s2_nxt.col[3][c] = div3(s1_r.num3[c]);
      end else begin
        s2_nxt.col[2][c] = s1_r.num2[c][8:1];
        s2_nxt.col[3][c] = '0;
      end
    end
    s2_nxt.alev[0] = s1_r.aw[7:0];
    s2_nxt.alev[1] = s1_r.aw[15:8];
    for (int k = 0; k < 6; k++) begin
      if (s1_r.gt) begin
        s2_nxt.alev[k + 2] = div7(s1_r.anum[k]);
      end else if (k < 4) begin
        s2_nxt.alev[k + 2] = div5(s1_r.anum[k]);
      end else if (k == 4) begin
        s2_nxt.alev[k + 2] = 8'd0;
      end else begin
        s2_nxt.alev[k + 2] = 8'd255;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_blk.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_blk.valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign pal_valid = s2_v_r;
  assign pal       = s2_r;

endmodule

/* hw/rtl/dxt_serializer.sv */
// ----------------------------------------------------------------------------
// dxt_serializer
// Holds one decoded palette and walks the sixteen texels in raster order,
// one per cycle while out_tx is not stalled, into a registered output.
// ----------------------------------------------------------------------------
module dxt_serializer
  import dxt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pal_valid,
  output logic       pal_ready,
  input  blk_pal_t   pal,
  dxt_texel_if.source out_tx
);

  logic       busy_r;
  logic [3:0] cnt_r;
  blk_pal_t   blk_r;
  logic       adv;
  logic       take;

  logic       out_v_r;
  logic [7:0] red_r;
  logic [7:0] green_r;
  logic [7:0] blue_r;
  logic [7:0] alpha_r;
  logic [3:0] pos_r;
  logic       last_r;

  logic [1:0] ci;
  logic [2:0] ai;
  logic [3:0] nib;
  logic [5:0] apos;
  rgb_t       col;
  logic [7:0] alpha_nxt;

  assign adv       = busy_r && (!out_v_r || out_tx.ready);
  assign pal_ready = !busy_r || (adv && cnt_r == LAST_POS);
  assign take      = pal_valid && pal_ready;

  always_comb begin
    ci   = blk_r.cidx[{cnt_r, 1'b0} +: 2];
    nib  = blk_r.aw[{cnt_r, 2'b00} +: 4];
    apos = 6'd16 + {2'b00, cnt_r} + {1'b0, cnt_r, 1'b0};
    ai   = blk_r.aw[apos +: 3];
    col  = blk_r.col[ci];
    unique case (blk_r.fmt)
      FMT_EXPLICIT: alpha_nxt = {nib, nib};
      FMT_INTERP:   alpha_nxt = blk_r.alev[ai];
      default: begin
        // three-colour mode: index 3 is transparent black
        alpha_nxt = (!blk_r.four && ci == IDX_BLACK) ? 8'd0 : 8'd255;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (adv) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LAST_POS) begin
          busy_r <= 1'b0;
        end
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tx.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blk_r <= pal;
    end
    if (adv) begin
      red_r   <= col[CH_R];
      green_r <= col[CH_G];
      blue_r  <= col[CH_B];
      alpha_r <= alpha_nxt;
      pos_r   <= cnt_r;
      last_r  <= (cnt_r == LAST_POS);
    end
  end

  assign out_tx.valid          = out_v_r;
  assign out_tx.texel_red      = red_r;
  assign out_tx.texel_green    = green_r;
  assign out_tx.texel_blue     = blue_r;
  assign out_tx.texel_alpha    = alpha_r;
  assign out_tx.texel_position = pos_r;
  assign out_tx.last_texel     = last_r;

endmodule

/* hw/rtl/dxt_texture_block_decoder_core.sv */
// ----------------------------------------------------------------------------
// dxt_texture_block_decoder_core
// S3TC (DXT1/DXT3/DXT5 style) block decoder: one compressed 4x4 block in,
// sixteen RGBA texels out in raster order, last one flagged.
//
//   channel   direction  handshake         payload
//   in_blk    in         valid/ready       alpha_word, color_word
//   out_tx    out        valid/ready       texel rgba, position, last_texel
//   cfg_*     in         cfg_we            cfg_wdata = block format
//
// a block yields sixteen texels, one texel per cycle out of the serializer
// while out_tx is not stalled; the next block is taken on the cycle its
// predecessor's last texel is issued; a block passes through the 2 palette
// stages, the serializer and the output register
// synchronous active-low reset clears valid bits and the format register
// a stall on out_tx holds every stage in place, nothing is dropped
// ----------------------------------------------------------------------------
module dxt_texture_block_decoder_core
  import dxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dxt_blk_if.sink     in_blk,
  dxt_texel_if.source out_tx,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  fmt_t     fmt_r;
  logic     pal_valid;
  logic     pal_ready;
  blk_pal_t pal;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_ONE_BIT;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  dxt_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt       (fmt_r),
    .in_blk    (in_blk),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal       (pal)
  );

  dxt_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal       (pal),
    .out_tx    (out_tx)
  );

endmodule
